FILE: hdl/psu_pkg.sv
// Package: shared constants, filter codes, register indexes and result type.
`default_nettype none

package psu_pkg;

   localparam int LINE_BYTES_MAX = 8192;
   localparam int PIXEL_BYTES_MAX = 8;
   localparam int POS_W = $clog2(LINE_BYTES_MAX);
   localparam int TAP_W = $clog2(PIXEL_BYTES_MAX);
   localparam int BPL_W = 14;
   localparam int BPP_W = 4;
   localparam int LINES_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BPP   = 2'd0,
      CSR_BPL   = 2'd1,
      CSR_LINES = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       line_end;
      logic       image_end;
      logic       bad_filter;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/psu_recon.sv
// Byte reconstruction: None, Sub, Up, Average and Paeth predictors.
`default_nettype none

module psu_recon (
   input  wire logic              [7:0] data_byte,
   input  wire psu_pkg::filt_type       filter,
   input  wire logic              [7:0] left_byte,
   input  wire logic              [7:0] up_byte,
   input  wire logic              [7:0] up_left_byte,
   output      logic              [7:0] recon_byte
);
   import psu_pkg::*;

   logic signed [9:0] pa;
   logic signed [9:0] pb;
   logic signed [9:0] pc;
   logic        [9:0] pa_abs;
   logic        [9:0] pb_abs;
   logic        [9:0] pc_abs;
   logic        [7:0] paeth;
   logic        [8:0] avg_sum;
   logic        [7:0] pred;

   always_comb begin
      pa = $signed({2'b00, up_byte}) - $signed({2'b00, up_left_byte});
      pb = $signed({2'b00, left_byte}) - $signed({2'b00, up_left_byte});
      pc = pa + pb;
      pa_abs = pa[9] ? 10'(-pa) : 10'(pa);
      pb_abs = pb[9] ? 10'(-pb) : 10'(pb);
      pc_abs = pc[9] ? 10'(-pc) : 10'(pc);
      if ((pa_abs <= pb_abs) && (pa_abs <= pc_abs)) begin
         paeth = left_byte;
      end else if (pb_abs <= pc_abs) begin
         paeth = up_byte;
      end else begin
         paeth = up_left_byte;
      end
      avg_sum = {1'b0, left_byte} + {1'b0, up_byte};
      case (filter)
         FILT_SUB:   pred = left_byte;
         FILT_UP:    pred = up_byte;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth;
         default:    pred = 8'd0;
      endcase
      recon_byte = data_byte + pred;
   end

endmodule

`default_nettype wire

FILE: hdl/psu_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module psu_out_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire psu_pkg::rsp_type push_data,
   output      logic             full,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      psu_pkg::rsp_type out_data
);
   import psu_pkg::*;

   logic    out_valid_ff;
   logic    out_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    pop;

   always_comb begin
      pop = out_valid_ff && out_ready;
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in = out_data_ff;
      skid_data_in = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff) begin
         if (pop && push) begin
            out_data_in = push_data;
         end else if (pop) begin
            out_valid_in = 1'b0;
         end else if (push) begin
            skid_data_in = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (push) begin
         out_data_in = push_data;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;

endmodule

`default_nettype wire

FILE: hdl/png_scanline_unfilter_core.sv
// Top level: PNG scanline filter reconstruction, one stream byte per cycle while req_ready is high.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_stream_byte, req_new_image
//   rsp      out        rsp_valid/rsp_ready    rsp_pixel_byte, rsp_line_end,
//                                              rsp_image_end, rsp_bad_filter
//   csr      in         csr_write_en           csr_index, csr_wdata
//
// One item per cycle while req_ready is high; each result is registered in the result buffer.
// The line memory is read one position ahead into a register, with a bypass
// for a read of the address written in the same cycle.
// Reset clears control state; the line memory needs no clearing pass.
// A two-entry result buffer drops req_ready only when both entries are held.
`default_nettype none

module png_scanline_unfilter_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                        [7:0] req_stream_byte,
   input  wire logic                              req_new_image,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic                        [7:0] rsp_pixel_byte,
   output      logic                              rsp_line_end,
   output      logic                              rsp_image_end,
   output      logic                              rsp_bad_filter,
   input  wire logic                              csr_write_en,
   input  wire logic     [psu_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic    [psu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import psu_pkg::*;

   logic [BPP_W-1:0]   bpp_ff;
   logic [BPL_W-1:0]   bpl_ff;
   logic [LINES_W-1:0] lines_cfg_ff;

   logic [7:0] left_ff [PIXEL_BYTES_MAX];
   logic [7:0] left_in [PIXEL_BYTES_MAX];
   logic [7:0] upl_ff [PIXEL_BYTES_MAX];
   logic [7:0] upl_in [PIXEL_BYTES_MAX];
   filt_type           filter_ff;
   filt_type           filter_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic [LINES_W-1:0] lines_ff;
   logic [LINES_W-1:0] lines_in;
   logic               expect_ff;
   logic               expect_in;
   logic               first_ff;
   logic               first_in;
   logic               fin_ff;
   logic               fin_in;

   logic [7:0]         line_mem [LINE_BYTES_MAX];
   logic [7:0]         rd_ff;
   logic               byp_ff;
   logic [7:0]         byp_data_ff;
   logic               mem_we;

   logic               accept;
   logic               buf_full;
   logic               push;
   rsp_type            push_data;
   rsp_type            out_data;

   logic [TAP_W-1:0]   tap;
   logic [BPL_W-1:0]   bpl_eff;
   logic [LINES_W-1:0] lines_eff;
   logic               fin_eff;
   logic               expect_eff;
   logic               first_eff;
   logic [LINES_W-1:0] lines_eff_cur;
   logic [7:0]         a_byte;
   logic [7:0]         b_byte;
   logic [7:0]         c_byte;
   logic [7:0]         recon;
   logic [LINES_W-1:0] lines_next;
   logic               last_line_byte;

   assign accept = req_valid && req_ready;
   assign req_ready = !buf_full;

   always_comb begin
      if (bpp_ff == '0) begin
         tap = '0;
      end else if (bpp_ff > BPP_W'(PIXEL_BYTES_MAX)) begin
         tap = TAP_W'(PIXEL_BYTES_MAX - 1);
      end else begin
         tap = TAP_W'(bpp_ff - BPP_W'(1));
      end
      if (bpl_ff == '0) begin
         bpl_eff = BPL_W'(1);
      end else if (bpl_ff > BPL_W'(LINE_BYTES_MAX)) begin
         bpl_eff = BPL_W'(LINE_BYTES_MAX);
      end else begin
         bpl_eff = bpl_ff;
      end
      lines_eff = (lines_cfg_ff == '0) ? LINES_W'(1) : lines_cfg_ff;
   end

   assign a_byte = left_ff[tap];
   assign c_byte = upl_ff[tap];
   assign b_byte = first_ff ? 8'd0 : (byp_ff ? byp_data_ff : rd_ff);

   psu_recon u_recon (
      .data_byte    (req_stream_byte),
      .filter       (filter_ff),
      .left_byte    (a_byte),
      .up_byte      (b_byte),
      .up_left_byte (c_byte),
      .recon_byte   (recon)
   );

   always_comb begin
      fin_eff = req_new_image ? 1'b0 : fin_ff;
      expect_eff = req_new_image ? 1'b1 : expect_ff;
      first_eff = req_new_image ? 1'b1 : first_ff;
      lines_eff_cur = req_new_image ? '0 : lines_ff;
      lines_next = lines_ff + LINES_W'(1);
      last_line_byte = (BPL_W'(pos_ff) + BPL_W'(1)) >= bpl_eff;

      left_in = left_ff;
      upl_in = upl_ff;
      filter_in = filter_ff;
      pos_in = pos_ff;
      lines_in = lines_ff;
      expect_in = expect_ff;
      first_in = first_ff;
      fin_in = fin_ff;
      mem_we = 1'b0;
      push = 1'b0;
      push_data = '0;

      if (accept) begin
         fin_in = fin_eff;
         expect_in = expect_eff;
         first_in = first_eff;
         lines_in = lines_eff_cur;
         if (req_new_image) begin
            pos_in = '0;
         end
         if (!fin_eff) begin
            if (expect_eff) begin
               expect_in = 1'b0;
               pos_in = '0;
               for (int i = 0; i < PIXEL_BYTES_MAX; i++) begin
                  left_in[i] = 8'd0;
                  upl_in[i] = 8'd0;
               end
               if (req_stream_byte > 8'(FILT_PAETH)) begin
                  filter_in = FILT_NONE;
                  push = 1'b1;
                  push_data.bad_filter = 1'b1;
               end else begin
                  filter_in = filt_type'(req_stream_byte[2:0]);
               end
            end else begin
               for (int i = PIXEL_BYTES_MAX - 1; i > 0; i--) begin
                  left_in[i] = left_ff[i-1];
                  upl_in[i] = upl_ff[i-1];
               end
               left_in[0] = recon;
               upl_in[0] = b_byte;
               mem_we = 1'b1;
               push = 1'b1;
               push_data.pixel_byte = recon;
               if (last_line_byte) begin
                  push_data.line_end = 1'b1;
                  lines_in = lines_next;
                  first_in = 1'b0;
                  expect_in = 1'b1;
                  pos_in = '0;
                  if ((lines_next >= lines_eff) || (lines_next == '0)) begin
                     push_data.image_end = 1'b1;
                     fin_in = 1'b1;
                  end
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[pos_ff] <= recon;
      end
      rd_ff <= line_mem[pos_in];
      byp_ff <= mem_we && (pos_in == pos_ff);
      byp_data_ff <= recon;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= BPP_W'(1);
         bpl_ff <= BPL_W'(1);
         lines_cfg_ff <= LINES_W'(1);
         for (int i = 0; i < PIXEL_BYTES_MAX; i++) begin
            left_ff[i] <= 8'd0;
            upl_ff[i] <= 8'd0;
         end
         filter_ff <= FILT_NONE;
         pos_ff <= '0;
         lines_ff <= '0;
         expect_ff <= 1'b1;
         first_ff <= 1'b1;
         fin_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_BPP:   bpp_ff <= csr_wdata[BPP_W-1:0];
               CSR_BPL:   bpl_ff <= csr_wdata[BPL_W-1:0];
               CSR_LINES: lines_cfg_ff <= csr_wdata[LINES_W-1:0];
               default:   ;
            endcase
         end
         left_ff <= left_in;
         upl_ff <= upl_in;
         filter_ff <= filter_in;
         pos_ff <= pos_in;
         lines_ff <= lines_in;
         expect_ff <= expect_in;
         first_ff <= first_in;
         fin_ff <= fin_in;
      end
   end

   psu_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_pixel_byte = out_data.pixel_byte;
   assign rsp_line_end = out_data.line_end;
   assign rsp_image_end = out_data.image_end;
   assign rsp_bad_filter = out_data.bad_filter;

   a_stall_holds_result : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result held");

   a_bad_filter_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_filter) |->
         (rsp_pixel_byte == 8'd0) && !rsp_line_end && !rsp_image_end)
      else $error("error result carries pixel data");

   a_finished_waits_filter : assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> expect_ff)
      else $error("image finished mid-line");

   a_finish_from_image_end : assert property (@(posedge clock) disable iff (reset)
      $rose(fin_ff) |-> $past(push && push_data.image_end))
      else $error("image finished without an end-of-image result");

endmodule

`default_nettype wire

FILE: bench/png_scanline_unfilter_core_test.sv
// Testbench for png_scanline_unfilter_core: scanline streams checked against a local model.
module png_scanline_unfilter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import psu_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [7:0] FIRST_BAD_CODE = 8'(FILT_PAETH) + 8'd1;
   localparam logic [7:0] LAST_BAD_CODE = 8'hFF;
   localparam logic [7:0] FILTER_WALK [25] = '{
      8'(FILT_SUB), 8'hFF, 8'h01, 8'h80, 8'h7F,
      8'(FILT_UP), 8'h00, 8'hFF, 8'h80, 8'h01,
      8'(FILT_AVG), 8'hFF, 8'hFF, 8'h00, 8'h01,
      8'(FILT_PAETH), 8'h7F, 8'h80, 8'hFF, 8'h00,
      FIRST_BAD_CODE, 8'h12, 8'h34, 8'h56, 8'h78
   };

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       new_image;
   } stream_item;

   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_RUNS} ready_style;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_stream_byte = 8'h00;
   logic                  req_new_image = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_pixel_byte;
   logic                  rsp_line_end;
   logic                  rsp_image_end;
   logic                  rsp_bad_filter;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   png_scanline_unfilter_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_stream_byte(req_stream_byte),
      .req_new_image(req_new_image),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_byte(rsp_pixel_byte),
      .rsp_line_end(rsp_line_end),
      .rsp_image_end(rsp_image_end),
      .rsp_bad_filter(rsp_bad_filter),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   stream_item  byte_feed [$];
   rsp_type     pixel_expect [$];
   int unsigned feed_count = 0;
   int unsigned taken_count = 0;
   int unsigned live_items = 0;
   int unsigned results_checked = 0;
   int unsigned bad_lines = 0;
   int unsigned images_closed = 0;
   int unsigned reg_writes = 0;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;

   // local copy of the block: registers and unfilter state
   logic [BPP_W-1:0]   bpp_reg;
   logic [BPL_W-1:0]   bpl_reg;
   logic [LINES_W-1:0] lines_reg;
   logic [7:0]         above_row [LINE_BYTES_MAX];
   logic [7:0]         left_taps [PIXEL_BYTES_MAX];
   logic [7:0]         above_left_taps [PIXEL_BYTES_MAX];
   filt_type           row_filter;
   int unsigned        row_pos;
   logic [LINES_W-1:0] rows_done;
   bit                 want_filter;
   bit                 on_top_row;
   bit                 image_closed;

   function automatic int unsigned pixel_stride();
      if (bpp_reg == 0) return 1;
      if (bpp_reg > PIXEL_BYTES_MAX) return PIXEL_BYTES_MAX;
      return bpp_reg;
   endfunction

   function automatic int unsigned row_span();
      if (bpl_reg == 0) return 1;
      if (bpl_reg > LINE_BYTES_MAX) return LINE_BYTES_MAX;
      return bpl_reg;
   endfunction

   function automatic int unsigned row_limit();
      return (lines_reg == 0) ? 1 : lines_reg;
   endfunction

   function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int p, pa, pb, pc;
      p = int'(a) + int'(b) - int'(c);
      pa = p - int'(a);
      pb = p - int'(b);
      pc = p - int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   task automatic clear_taps();
      for (int i = 0; i < PIXEL_BYTES_MAX; i++) begin
         left_taps[i] = 8'h00;
         above_left_taps[i] = 8'h00;
      end
   endtask

   task automatic restart_image();
      clear_taps();
      row_filter = FILT_NONE;
      row_pos = 0;
      rows_done = '0;
      want_filter = 1'b1;
      on_top_row = 1'b1;
      image_closed = 1'b0;
   endtask

   task automatic unfilter_byte(input logic [7:0] data, input logic fresh);
      rsp_type     res;
      int unsigned stride;
      logic [7:0]  a, b, c, guess, recon;
      if (fresh) restart_image();
      if (image_closed) return;
      if (want_filter) begin
         want_filter = 1'b0;
         row_pos = 0;
         clear_taps();
         if (data > 8'(FILT_PAETH)) begin
            row_filter = FILT_NONE;
            res = '{pixel_byte: 8'h00, line_end: 1'b0, image_end: 1'b0, bad_filter: 1'b1};
            pixel_expect.push_back(res);
            bad_lines++;
         end else begin
            row_filter = filt_type'(data[2:0]);
         end
         return;
      end
      stride = pixel_stride();
      a = left_taps[stride - 1];
      c = above_left_taps[stride - 1];
      b = on_top_row ? 8'h00 : above_row[row_pos];
      case (row_filter)
         FILT_SUB:   guess = a;
         FILT_UP:    guess = b;
         FILT_AVG:   guess = 8'((9'(a) + 9'(b)) >> 1);
         FILT_PAETH: guess = paeth_pick(a, b, c);
         default:    guess = 8'h00;
      endcase
      recon = data + guess;
      for (int i = PIXEL_BYTES_MAX - 1; i > 0; i--) begin
         left_taps[i] = left_taps[i - 1];
         above_left_taps[i] = above_left_taps[i - 1];
      end
      left_taps[0] = recon;
      above_left_taps[0] = b;
      above_row[row_pos] = recon;
      res = '{pixel_byte: recon, line_end: 1'b0, image_end: 1'b0, bad_filter: 1'b0};
      if (row_pos + 1 >= row_span()) begin
         res.line_end = 1'b1;
         rows_done = rows_done + 1'b1;
         on_top_row = 1'b0;
         want_filter = 1'b1;
         row_pos = 0;
         if (rows_done >= row_limit() || rows_done == 0) begin
            res.image_end = 1'b1;
            image_closed = 1'b1;
            images_closed++;
         end
      end else begin
         row_pos++;
      end
      pixel_expect.push_back(res);
   endtask

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   // sender: bursts of random length separated by random gaps
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   always @(posedge clock) begin
      stream_item next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0 || byte_feed.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            next_item = byte_feed.pop_front();
            req_valid <= 1'b1;
            req_stream_byte <= next_item.stream_byte;
            req_new_image <= next_item.new_image;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
      end
   end

   // receiver: stall style changes at random intervals
   ready_style  ready_mode = READY_ALWAYS;
   int unsigned mode_left = 0;
   int unsigned run_left = 0;
   logic        run_level = 1'b1;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_style'($urandom_range(int'(READY_ALWAYS), int'(READY_RUNS)));
         mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (run_left == 0) begin
         run_level = !run_level;
         run_left = $urandom_range(1, 8);
      end
      run_left--;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         default:      rsp_ready <= run_level;
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_expect.size() == 0) begin
               failures++;
               $display("%0t ns: result expected none, got pixel_byte %0h bad_filter %0b",
                        $time, rsp_pixel_byte, rsp_bad_filter);
            end else begin
               want = pixel_expect.pop_front();
               compare_field("pixel_byte", want.pixel_byte, rsp_pixel_byte);
               compare_field("line_end", 8'(want.line_end), 8'(rsp_line_end));
               compare_field("image_end", 8'(want.image_end), 8'(rsp_image_end));
               compare_field("bad_filter", 8'(want.bad_filter), 8'(rsp_bad_filter));
               results_checked++;
            end
         end
         if (req_valid && req_ready) begin
            unfilter_byte(req_stream_byte, req_new_image);
            taken_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] value, input logic fresh);
      byte_feed.push_back('{stream_byte: value, new_image: fresh});
      feed_count++;
   endtask

   task automatic settle();
      do @(posedge clock);
      while (taken_count != feed_count || pixel_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_BPP:   bpp_reg = value[BPP_W-1:0];
         CSR_BPL:   bpl_reg = value[BPL_W-1:0];
         CSR_LINES: lines_reg = value[LINES_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic queue_image(input int unsigned rows, input int unsigned span, input bit fresh);
      logic [7:0] code;
      for (int unsigned r = 0; r < rows; r++) begin
         if ($urandom_range(0, 6) == 0)
            code = 8'($urandom_range(int'(FIRST_BAD_CODE), int'(LAST_BAD_CODE)));
         else
            code = 8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH)));
         queue_byte(code, fresh && r == 0);
         for (int unsigned k = 0; k < span; k++)
            queue_byte(8'($urandom), $urandom_range(0, 299) == 0);
         live_items += span + 1;
      end
   endtask

   task automatic random_phase();
      logic [CSR_DATA_W-1:0] bpp_val, bpl_val, lines_val;
      int unsigned rows, limit;
      case ($urandom_range(0, 9))
         0:       bpp_val = 16'd0;
         1:       bpp_val = 16'($urandom_range(PIXEL_BYTES_MAX + 1, 15));
         default: bpp_val = 16'($urandom_range(1, PIXEL_BYTES_MAX));
      endcase
      if ($urandom_range(0, 1) == 0) bpp_val[15:BPP_W] = 12'($urandom);
      case ($urandom_range(0, 9))
         0:       bpl_val = 16'd0;
         1, 2:    bpl_val = 16'($urandom_range(17, 80));
         default: bpl_val = 16'($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 3) == 0) bpl_val[15:BPL_W] = 2'($urandom);
      case ($urandom_range(0, 9))
         0:       lines_val = 16'd0;
         1:       lines_val = 16'hFFFF;
         default: lines_val = 16'($urandom_range(1, 6));
      endcase
      write_reg(CSR_BPP, bpp_val);
      write_reg(CSR_BPL, bpl_val);
      write_reg(CSR_LINES, lines_val);
      if ($urandom_range(0, 15) == 0) write_reg(CSR_SPARE, 16'($urandom));
      limit = row_limit();
      repeat ($urandom_range(1, 3)) begin
         if (lines_val == 16'hFFFF)
            rows = $urandom_range(1, 5);
         else if ($urandom_range(0, 7) == 0)
            rows = $urandom_range(1, limit);
         else
            rows = limit + $urandom_range(0, 1);
         queue_image(rows, row_span(), 1'b1);
         repeat ($urandom_range(0, 2)) queue_byte(8'($urandom), 1'b0);
      end
      settle();
   endtask

   initial begin
      bpp_reg = 1;
      bpl_reg = 1;
      lines_reg = 1;
      restart_image();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset defaults, bytes past the image, then a marked restart
      queue_byte(8'(FILT_SUB), 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'(FILT_PAETH), 1'b1);
      queue_byte(8'h80, 1'b0);
      settle();

      // every filter type but None, then an unknown one whose line passes through as None
      write_reg(CSR_BPP, 16'd2);
      write_reg(CSR_BPL, 16'd4);
      write_reg(CSR_LINES, 16'd5);
      for (int k = 0; k < 25; k++) queue_byte(FILTER_WALK[k], k == 0);
      queue_byte(8'h5A, 1'b0);
      settle();

      // shorten a line in flight
      write_reg(CSR_BPP, 16'd1);
      write_reg(CSR_BPL, 16'd6);
      write_reg(CSR_LINES, 16'd3);
      queue_byte(8'(FILT_SUB), 1'b1);
      repeat (3) queue_byte(8'($urandom), 1'b0);
      settle();
      write_reg(CSR_BPL, 16'd2);
      queue_byte(8'($urandom), 1'b0);
      queue_image(2, 2, 1'b0);
      queue_byte(LAST_BAD_CODE, 1'b1);
      repeat (2) queue_byte(8'($urandom), 1'b0);
      settle();

      // drop the line count below the lines already done
      write_reg(CSR_BPP, 16'd2);
      write_reg(CSR_LINES, 16'd5);
      queue_image(3, 2, 1'b1);
      settle();
      write_reg(CSR_LINES, 16'd1);
      queue_image(1, 2, 1'b0);
      repeat (2) queue_byte(8'($urandom), 1'b0);
      settle();

      // widest pixel clamped from an out-of-range value, line length with stray upper bits
      write_reg(CSR_BPP, 16'hFFFF);
      write_reg(CSR_BPL, 16'hC018);
      write_reg(CSR_LINES, 16'd2);
      queue_image(2, row_span(), 1'b1);
      settle();

      live_items = 0;
      while (live_items < RANDOM_ITEMS) random_phase();

      $display("Stream bytes accepted: %0d, results checked: %0d, register writes: %0d",
               taken_count, results_checked, reg_writes);
      $display("Images completed: %0d, unknown filter lines: %0d", images_closed, bad_lines);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
